// ===== sv/dsp_pkg.sv =====
package dsp_pkg;

  // Default sizing of the engine.
  localparam int unsigned DEF_VERTICES    = 16;
  localparam int unsigned DEF_WEIGHT_BITS = 8;

  // Fixed field widths of the request and result channels.
  localparam int unsigned VERT_W     = 4;
  localparam int unsigned WGT_IN_W   = 8;
  localparam int unsigned DIST_W     = 14;
  localparam int unsigned MAX_REPORT = 16;

  localparam logic [DIST_W-1:0] UNREACHABLE = 14'd9999;

  // Request kinds.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_RUN  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wt_we;       // write one matrix weight from the request
    logic run_start;   // capture the start vertex, clear visited flags
    logic init_step;   // write one initial distance, advance the counter
    logic scan_clr;    // restart the vertex counter and the minimum search
    logic pick_step;   // minimum search over unvisited vertices
    logic commit;      // mark the chosen vertex visited and latch it
    logic relax_step;  // relax the edges of the chosen vertex
    logic out_load;    // load the result register from the distance store
    logic out_next;    // advance to the next reported vertex
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_last;     // counter is on the last vertex
    logic scan_done;    // all reads of a scan issued and consumed
    logic found;        // the minimum search found a reachable vertex
    logic rounds_done;  // all rounds of the search are done
    logic out_last;     // counter is on the last reported vertex
    logic out_taken;    // the result register transfer completes
  } dp_stat_t;

endpackage

// ===== sv/dsp_ram.sv =====
module dsp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/dsp_datapath.sv =====
module dsp_datapath #(
  parameter int unsigned VERTICES    = dsp_pkg::DEF_VERTICES,
  parameter int unsigned WEIGHT_BITS = dsp_pkg::DEF_WEIGHT_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dsp_pkg::dp_cmd_t              cmd_i,
  output dsp_pkg::dp_stat_t             stat_o,
  input  logic [dsp_pkg::VERT_W-1:0]    row_vertex_i,
  input  logic [dsp_pkg::VERT_W-1:0]    col_vertex_i,
  input  logic [dsp_pkg::WGT_IN_W-1:0]  edge_weight_i,
  input  logic [dsp_pkg::VERT_W-1:0]    start_vertex_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [dsp_pkg::VERT_W-1:0]    vertex_index_o,
  output logic [dsp_pkg::DIST_W-1:0]    path_distance_o,
  output logic                          last_result_o
);
  import dsp_pkg::*;

  localparam int unsigned VB     = $clog2(VERTICES);
  localparam int unsigned CW     = $clog2(VERTICES + 1);
  localparam int unsigned MD     = VERTICES * VERTICES;
  localparam int unsigned WA     = $clog2(MD);
  localparam int unsigned SW     = DIST_W + 1;
  localparam int unsigned REPORT = (VERTICES < MAX_REPORT) ? VERTICES : MAX_REPORT;

  logic [CW-1:0]          cnt_q, cnt_d;
  logic                   rd_vld_q, rd_vld_d;
  logic [VB-1:0]          rd_idx_q, rd_idx_d;
  logic [DIST_W-1:0]      best_q, best_d;
  logic [VB-1:0]          best_idx_q, best_idx_d;
  logic                   found_q, found_d;
  logic [VB-1:0]          u_q, u_d;
  logic [DIST_W-1:0]      du_q, du_d;
  logic [VB-1:0]          round_q, round_d;
  logic [VERTICES-1:0]    visited_q, visited_d;
  logic [VERT_W-1:0]      start_q, start_d;
  logic                   out_vld_q, out_vld_d;
  logic [VERT_W-1:0]      out_idx_q, out_idx_d;
  logic [DIST_W-1:0]      out_dist_q, out_dist_d;
  logic                   out_last_q, out_last_d;

  logic                   wt_we;
  logic [WA-1:0]          wt_waddr, wt_raddr;
  logic [WEIGHT_BITS-1:0] wt_rdata;
  logic                   dist_we;
  logic [VB-1:0]          dist_waddr;
  logic [DIST_W-1:0]      dist_wdata, dist_rdata;

  logic [SW-1:0]          cand;
  logic [DIST_W-1:0]      cand_sat;
  logic                   relax_hit, pick_hit, start_hit, issue;

  // Weight matrix, row-major.
  assign wt_we    = cmd_i.wt_we && (32'(row_vertex_i) < VERTICES)
                    && (32'(col_vertex_i) < VERTICES);
  assign wt_waddr = WA'(row_vertex_i) * WA'(VERTICES) + WA'(col_vertex_i);
  assign wt_raddr = WA'(u_q) * WA'(VERTICES) + WA'(cnt_q[VB-1:0]);

  dsp_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (MD)
  ) u_wt_ram (
    .clk_i   (clk_i),
    .we_i    (wt_we),
    .waddr_i (wt_waddr),
    .wdata_i (edge_weight_i[WEIGHT_BITS-1:0]),
    .raddr_i (wt_raddr),
    .rdata_o (wt_rdata)
  );

  dsp_ram #(
    .WIDTH (DIST_W),
    .DEPTH (VERTICES)
  ) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (dist_we),
    .waddr_i (dist_waddr),
    .wdata_i (dist_wdata),
    .raddr_i (cnt_q[VB-1:0]),
    .rdata_o (dist_rdata)
  );

  always_comb begin
    cand      = SW'(du_q) + SW'(wt_rdata);
    cand_sat  = (cand > SW'(UNREACHABLE)) ? UNREACHABLE : cand[DIST_W-1:0];
    relax_hit = cmd_i.relax_step && rd_vld_q && (wt_rdata != '0)
                && !visited_q[rd_idx_q] && (dist_rdata > cand_sat);
    pick_hit  = cmd_i.pick_step && rd_vld_q && !visited_q[rd_idx_q]
                && (dist_rdata < best_q);
    start_hit = (32'(start_q) == 32'(cnt_q));
    issue     = (cmd_i.pick_step || cmd_i.relax_step) && (cnt_q < CW'(VERTICES));

    dist_we    = cmd_i.init_step || relax_hit;
    dist_waddr = cmd_i.init_step ? cnt_q[VB-1:0] : rd_idx_q;
    if (cmd_i.init_step) begin
      dist_wdata = start_hit ? '0 : UNREACHABLE;
    end else begin
      dist_wdata = cand_sat;
    end
  end

  always_comb begin
    cnt_d      = cnt_q;
    rd_vld_d   = 1'b0;
    rd_idx_d   = rd_idx_q;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    found_d    = found_q;
    u_d        = u_q;
    du_d       = du_q;
    round_d    = round_q;
    visited_d  = visited_q;
    start_d    = start_q;
    out_vld_d  = out_vld_q;
    out_idx_d  = out_idx_q;
    out_dist_d = out_dist_q;
    out_last_d = out_last_q;

    if (cmd_i.run_start) begin
      start_d   = start_vertex_i;
      visited_d = '0;
      round_d   = '0;
      cnt_d     = '0;
    end
    if (cmd_i.init_step || cmd_i.out_next) begin
      cnt_d = cnt_q + CW'(1);
    end
    if (issue) begin
      rd_vld_d = 1'b1;
      rd_idx_d = cnt_q[VB-1:0];
      cnt_d    = cnt_q + CW'(1);
    end
    if (pick_hit) begin
      best_d     = dist_rdata;
      best_idx_d = rd_idx_q;
      found_d    = 1'b1;
    end
    if (cmd_i.commit) begin
      visited_d[best_idx_q] = 1'b1;
      u_d      = best_idx_q;
      du_d     = best_q;
      round_d  = round_q + VB'(1);
      cnt_d    = '0;
      rd_vld_d = 1'b0;
    end
    if (cmd_i.scan_clr) begin
      cnt_d    = '0;
      rd_vld_d = 1'b0;
      best_d   = UNREACHABLE;
      found_d  = 1'b0;
    end
    if (cmd_i.out_load) begin
      out_vld_d  = 1'b1;
      out_idx_d  = VERT_W'(cnt_q);
      out_dist_d = dist_rdata;
      out_last_d = (cnt_q == CW'(REPORT - 1));
    end else if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      found_q   <= 1'b0;
      round_q   <= '0;
      visited_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      rd_vld_q  <= rd_vld_d;
      found_q   <= found_d;
      round_q   <= round_d;
      visited_q <= visited_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    u_q        <= u_d;
    du_q       <= du_d;
    start_q    <= start_d;
    out_idx_q  <= out_idx_d;
    out_dist_q <= out_dist_d;
    out_last_q <= out_last_d;
  end

  always_comb begin
    stat_o.cnt_last    = (cnt_q == CW'(VERTICES - 1));
    stat_o.scan_done   = (cnt_q == CW'(VERTICES)) && !rd_vld_q;
    stat_o.found       = found_q;
    stat_o.rounds_done = (round_q == VB'(VERTICES - 1));
    stat_o.out_last    = (cnt_q == CW'(REPORT - 1));
    stat_o.out_taken   = out_vld_q && out_ready_i;
  end

  assign out_valid_o     = out_vld_q;
  assign vertex_index_o  = out_idx_q;
  assign path_distance_o = out_dist_q;
  assign last_result_o   = out_last_q;

endmodule

// ===== sv/dsp_ctrl.sv =====
module dsp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              req_type_i,
  output logic              in_ready_o,
  input  dsp_pkg::dp_stat_t stat_i,
  output dsp_pkg::dp_cmd_t  cmd_o
);
  import dsp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_PICK,
    ST_RELAX,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_WAIT
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_q) begin
          if (req_type_i == REQ_LOAD) begin
            cmd_o.wt_we = 1'b1;
          end else begin
            cmd_o.run_start = 1'b1;
            state_d         = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        cmd_o.init_step = 1'b1;
        if (stat_i.cnt_last) begin
          cmd_o.scan_clr = 1'b1;
          state_d        = ST_PICK;
        end
      end
      ST_PICK: begin
        cmd_o.pick_step = 1'b1;
        if (stat_i.scan_done) begin
          if (stat_i.found) begin
            cmd_o.commit = 1'b1;
            state_d      = ST_RELAX;
          end else begin
            cmd_o.scan_clr = 1'b1;
            state_d        = ST_OUT_RD;
          end
        end
      end
      ST_RELAX: begin
        cmd_o.relax_step = 1'b1;
        if (stat_i.scan_done) begin
          cmd_o.scan_clr = 1'b1;
          state_d        = stat_i.rounds_done ? ST_OUT_RD : ST_PICK;
        end
      end
      ST_OUT_RD: begin
        state_d = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        cmd_o.out_load = 1'b1;
        state_d        = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        if (stat_i.out_taken) begin
          if (stat_i.out_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.out_next = 1'b1;
            state_d        = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      in_ready_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      in_ready_q <= (state_d == ST_IDLE);
    end
  end

  assign in_ready_o = in_ready_q;

endmodule

// ===== sv/dense_shortest_path_engine_top.sv =====
// Load request: one transfer per cycle back to back, no result.
// Run request: distance setup, then up to V-1 rounds of two scans each
// (minimum search, then edge relaxation); then each reported distance passes
// through a read, a load and a wait-for-transfer state.
// Reset (asynchronous, active low) clears the controller, counters and visited
// flags; the weight matrix and distance store are not cleared.
module dense_shortest_path_engine_top #(
  parameter int unsigned VERTICES    = dsp_pkg::DEF_VERTICES,
  parameter int unsigned WEIGHT_BITS = dsp_pkg::DEF_WEIGHT_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic [dsp_pkg::VERT_W-1:0]    row_vertex_i,
  input  logic [dsp_pkg::VERT_W-1:0]    col_vertex_i,
  input  logic [dsp_pkg::WGT_IN_W-1:0]  edge_weight_i,
  input  logic [dsp_pkg::VERT_W-1:0]    start_vertex_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [dsp_pkg::VERT_W-1:0]    vertex_index_o,
  output logic [dsp_pkg::DIST_W-1:0]    path_distance_o,
  output logic                          last_result_o
);
  import dsp_pkg::*;

  // The controller sequences a run through setup, alternating minimum search
  // and relaxation scans, and the result phase. It only accepts a request
  // transfer while idle, so a new request never overlaps a run in progress.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  dsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // The datapath holds the weight matrix and the distance store as RAMs with
  // registered reads. Each scan streams one vertex per cycle through the read
  // port and consumes each read in the cycle after its issue, so the visited
  // flags and the running minimum live in flip-flops next to the RAMs.
  dsp_datapath #(
    .VERTICES    (VERTICES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .row_vertex_i    (row_vertex_i),
    .col_vertex_i    (col_vertex_i),
    .edge_weight_i   (edge_weight_i),
    .start_vertex_i  (start_vertex_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .vertex_index_o  (vertex_index_o),
    .path_distance_o (path_distance_o),
    .last_result_o   (last_result_o)
  );

endmodule

// ===== sv/dsp_checker.sv =====
module dsp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [dsp_pkg::VERT_W-1:0]    vertex_index_o,
  input logic [dsp_pkg::DIST_W-1:0]    path_distance_o,
  input logic                          last_result_o
);
  import dsp_pkg::*;

  // A pending result holds until its transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(vertex_index_o)
      && $stable(path_distance_o) && $stable(last_result_o))
    else $error("result changed while stalled");

  // No request is taken while a result is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("request ready while a result is pending");

  // Reported distances never exceed the unreachable marker.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> path_distance_o <= UNREACHABLE)
    else $error("distance above unreachable value");

  // The final result of a run returns the engine to idle, any other does not.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> (in_ready_o == $past(last_result_o)))
    else $error("idle state does not follow the last result");

endmodule

bind dense_shortest_path_engine_top dsp_checker u_dsp_checker (.*);

// ===== dv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dsp_pkg::*;

  // The engine runs at its default size. Search indexes below are plain
  // integers that are sized to VERTICES, except the fixed ones of the tie case.
  localparam int unsigned VERTICES    = DEF_VERTICES;
  localparam int unsigned WEIGHT_BITS = DEF_WEIGHT_BITS;
  localparam int unsigned REPORTED    = (VERTICES < MAX_REPORT) ? VERTICES : MAX_REPORT;
  localparam int unsigned RANDOM_REQS = 200;

  // One distance report as the result channel carries it.
  typedef struct {
    logic [VERT_W-1:0] vertex;
    logic [DIST_W-1:0] distance;
    logic              last;
  } distance_report_t;

  // The scoreboard keeps its own copy of the weight matrix. Every load that
  // the engine accepts updates it. Every accepted search is solved here at
  // once, and its reports are queued for the result monitor.
  class path_scoreboard;
    bit [WEIGHT_BITS-1:0] weights [VERTICES][VERTICES];
    distance_report_t     pending_reports [$];
    int unsigned          errors;
    int unsigned          checked;

    function void note_request(logic kind, logic [VERT_W-1:0] row, logic [VERT_W-1:0] col,
                               logic [WGT_IN_W-1:0] wt, logic [VERT_W-1:0] start);
      if (kind == REQ_LOAD) begin
        if (row < VERTICES && col < VERTICES) begin
          weights[row][col] = wt[WEIGHT_BITS-1:0];
        end
      end else begin
        solve_from(start);
      end
    endfunction

    function void solve_from(int unsigned start);
      int unsigned      span [VERTICES];
      bit               done [VERTICES];
      int unsigned      best;
      int unsigned      cand;
      int               pick;
      distance_report_t rep;
      for (int i = 0; i < VERTICES; i++) begin
        span[i] = UNREACHABLE;
        done[i] = 1'b0;
      end
      if (start < VERTICES) begin
        span[start] = 0;
      end
      for (int round = 0; round < VERTICES - 1; round++) begin
        // Closest unvisited vertex; the strict compare keeps the lowest index.
        best = UNREACHABLE;
        pick = -1;
        for (int i = 0; i < VERTICES; i++) begin
          if (!done[i] && span[i] < best) begin
            best = span[i];
            pick = i;
          end
        end
        if (pick < 0) begin
          break;
        end
        done[pick] = 1'b1;
        for (int v = 0; v < VERTICES; v++) begin
          if (weights[pick][v] != 0 && !done[v]) begin
            cand = span[pick] + weights[pick][v];
            if (cand > UNREACHABLE) begin
              cand = UNREACHABLE;
            end
            if (span[v] > cand) begin
              span[v] = cand;
            end
          end
        end
      end
      for (int k = 0; k < REPORTED; k++) begin
        rep.vertex   = k[VERT_W-1:0];
        rep.distance = span[k][DIST_W-1:0];
        rep.last     = (k == REPORTED - 1);
        pending_reports.push_back(rep);
      end
    endfunction

    function void check_report(logic [VERT_W-1:0] vertex, logic [DIST_W-1:0] distance,
                               logic last);
      distance_report_t want;
      if (pending_reports.size() == 0) begin
        $error("Unexpected distance report: vertex %0d distance %0d last %0b",
               vertex, distance, last);
        errors++;
        return;
      end
      want = pending_reports.pop_front();
      checked++;
      if (vertex !== want.vertex) begin
        $error("vertex_index: expected %0d, got %0d", want.vertex, vertex);
        errors++;
      end
      if (distance !== want.distance) begin
        $error("path_distance: expected %0d, got %0d (vertex %0d)",
               want.distance, distance, want.vertex);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_result: expected %0b, got %0b (vertex %0d)", want.last, last, want.vertex);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_reports.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni          = 1'b0;
  logic                in_valid_i      = 1'b0;
  logic                in_ready_o;
  logic                req_type_i      = REQ_LOAD;
  logic [VERT_W-1:0]   row_vertex_i    = '0;
  logic [VERT_W-1:0]   col_vertex_i    = '0;
  logic [WGT_IN_W-1:0] edge_weight_i   = '0;
  logic [VERT_W-1:0]   start_vertex_i  = '0;
  logic                out_valid_o;
  logic                out_ready_i     = 1'b0;
  logic [VERT_W-1:0]   vertex_index_o;
  logic [DIST_W-1:0]   path_distance_o;
  logic                last_result_o;

  path_scoreboard routes = new;
  bit             quiet;          // when set, neither side inserts idle cycles
  int unsigned    loads_sent;
  int unsigned    searches_sent;

  dense_shortest_path_engine_top #(
    .VERTICES   (VERTICES),
    .WEIGHT_BITS(WEIGHT_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .row_vertex_i   (row_vertex_i),
    .col_vertex_i   (col_vertex_i),
    .edge_weight_i  (edge_weight_i),
    .start_vertex_i (start_vertex_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .vertex_index_o (vertex_index_o),
    .path_distance_o(path_distance_o),
    .last_result_o  (last_result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Idle lengths: none in almost half of the draws, else a random gap, now and
  // then a long pause that can land on any phase of a search or of the result stream.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Edge weights lean on "no edge" and on both extremes, so that graphs come
  // out sparse enough to leave vertices unreachable and ties are common.
  function automatic logic [WGT_IN_W-1:0] pick_weight();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return '0;
    if (r < 50) return 8'd1;
    if (r < 58) return 8'd255;
    if (r < 75) return 8'($urandom_range(1, 8));
    return 8'($urandom_range(1, 255));
  endfunction

  // Presents one request and holds it until the transfer happens. The valid
  // is lowered only when an idle gap follows, so a back-to-back request never
  // sees a low and a high assigned in the same time step. The fields that the
  // request kind ignores still carry random bits.
  task automatic send_request(input logic kind, input logic [VERT_W-1:0] row,
                              input logic [VERT_W-1:0] col, input logic [WGT_IN_W-1:0] wt,
                              input logic [VERT_W-1:0] start);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= kind;
    row_vertex_i   <= row;
    col_vertex_i   <= col;
    edge_weight_i  <= wt;
    start_vertex_i <= start;
    do @(posedge clk_i); while (!in_ready_o);
    routes.note_request(kind, row, col, wt, start);
    if (kind == REQ_LOAD) begin
      loads_sent++;
    end else begin
      searches_sent++;
    end
  endtask

  task automatic load_edge(input int unsigned row, input int unsigned col,
                           input logic [WGT_IN_W-1:0] wt);
    send_request(REQ_LOAD, row[VERT_W-1:0], col[VERT_W-1:0], wt, VERT_W'($urandom));
  endtask

  task automatic run_search(input int unsigned start);
    send_request(REQ_RUN, VERT_W'($urandom), VERT_W'($urandom), WGT_IN_W'($urandom),
                 start[VERT_W-1:0]);
  endtask

  // Result side: ready is high for a random stretch, then drops for a random
  // gap, so stalls fall both inside a report stream and between searches.
  initial begin
    int unsigned hold;
    int unsigned gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      out_ready_i <= 1'b1;
      hold = $urandom_range(1, 30);
      repeat (hold) @(posedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  // Every result transfer is checked against the oldest queued report.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      routes.check_report(vertex_index_o, path_distance_o, last_result_o);
    end
  end

  initial begin
    int unsigned burst;
    int unsigned sent;
    int unsigned row;
    int unsigned r;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The matrix has no reset value, so every entry is written before the
    // first search. Starting from an empty graph also gives the early end of
    // the search, on the round after the start vertex is taken.
    for (int i = 0; i < VERTICES; i++) begin
      for (int j = 0; j < VERTICES; j++) begin
        load_edge(i, j, '0);
      end
    end

    // Empty graph: only the start is at zero, from both ends of the range.
    run_search(0);
    run_search(VERTICES - 1);

    // A chain of the heaviest edges gives the largest reachable distance at
    // the far end; searching from the tail reaches nothing beyond itself.
    for (int k = 0; k < VERTICES - 1; k++) begin
      load_edge(k, k + 1, 8'd255);
    end
    run_search(0);
    run_search(VERTICES - 1);

    // Two vertices at the same distance: the lower index must be taken
    // first, and a later, shorter path must still win the relaxation.
    load_edge(15, 7, 8'd1);
    load_edge(15, 3, 8'd1);
    load_edge(3, 9, 8'd2);
    load_edge(7, 9, 8'd1);
    run_search(15);

    // Random part. Most of it is bursts of random edge loads closed by a
    // search from a random start. The rest is single loads, searches back to
    // back, and whole rows rewritten, which can cut a vertex off again.
    sent = 0;
    while (sent < RANDOM_REQS) begin
      quiet = (sent >= 80 && sent < 120);
      r = $urandom_range(0, 99);
      if (r < 70) begin
        burst = $urandom_range(1, 16);
        repeat (burst) begin
          load_edge($urandom_range(0, VERTICES - 1), $urandom_range(0, VERTICES - 1),
                    pick_weight());
        end
        run_search($urandom_range(0, VERTICES - 1));
        sent += burst + 1;
      end else if (r < 80) begin
        row = $urandom_range(0, VERTICES - 1);
        for (int j = 0; j < VERTICES; j++) begin
          load_edge(row, j, pick_weight());
        end
        run_search($urandom_range(0, VERTICES - 1));
        sent += VERTICES + 1;
      end else if (r < 90) begin
        run_search($urandom_range(0, VERTICES - 1));
        run_search($urandom_range(0, VERTICES - 1));
        sent += 2;
      end else begin
        load_edge($urandom_range(0, VERTICES - 1), $urandom_range(0, VERTICES - 1),
                  WGT_IN_W'($urandom));
        sent += 1;
      end
    end
    quiet = 1'b0;

    // The last request was taken at this edge, so its valid drops right here.
    in_valid_i <= 1'b0;

    // Drain, then give the engine time to show any stray result transfer.
    while (routes.outstanding() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("Sent %0d weight loads and %0d searches with random idling on both sides.",
             loads_sent, searches_sent);
    $display("Checked %0d distance reports, %0d mismatches.", routes.checked, routes.errors);
    if (routes.errors == 0 && routes.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Well over ten times the slowest legal run.
  initial begin
    #15_000_000;
    $display("Timeout with %0d distance reports still outstanding.", routes.outstanding());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
